// File: rtl/lattice_coeff_compress_pack_assert.svh
// Assertion macros used by the checker file.
`ifndef LATTICE_COEFF_COMPRESS_PACK_ASSERT_SVH
`define LATTICE_COEFF_COMPRESS_PACK_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define LCC_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LCC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lcc_pkg.sv
package lcc_pkg;

    // Fixed field geometry
    localparam int GROUP_SIZE = 8;
    localparam int COEFF_W    = 12;
    localparam int VAL_W      = 5;
    localparam int BITS_W     = 3;
    localparam int PACKED_W   = 40;
    // Compress numerator (c << d) + Q/2 stays below 2^18 for any modulus that fits in COEFF_W
    localparam int NUM_W      = 18;

    localparam logic [BITS_W-1:0] BITS_MIN   = 3'd1;
    localparam logic [BITS_W-1:0] BITS_MAX   = 3'd5;
    localparam logic [BITS_W-1:0] BITS_RESET = 3'd4;

    // Function codes
    localparam logic FUNC_COMPRESS   = 1'b0;
    localparam logic FUNC_DECOMPRESS = 1'b1;

    // Register map
    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_COMPRESS_BITS = 1'b0;

    // Stage loads and per-stage mode passed to every lane
    typedef struct packed {
        logic              ld1;
        logic              ld2;
        logic              ld3;
        logic              func0;
        logic [BITS_W-1:0] d0;
        logic              func1;
        logic              func2;
        logic [BITS_W-1:0] d2;
    } lcc_ctl_t;

    // Saturate the raw register to the supported range
    function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] raw);
        logic [BITS_W-1:0] d;
        d = raw;
        if (d < BITS_MIN) d = BITS_MIN;
        if (d > BITS_MAX) d = BITS_MAX;
        return d;
    endfunction

    // Low d bits set
    function automatic logic [VAL_W-1:0] bits_mask(input logic [BITS_W-1:0] d);
        logic [VAL_W-1:0] m;
        m = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (i < int'(d)) m[i] = 1'b1;
        end
        return m;
    endfunction

    // Rounding term 2^(d-1)
    function automatic logic [VAL_W-1:0] round_bit(input logic [BITS_W-1:0] d);
        logic [VAL_W-1:0] r;
        r = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (i == int'(d) - 1) r[i] = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/lcc_in_if.sv
interface lcc_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [lcc_pkg::PACKED_W-1:0]      in_packed;
    logic [lcc_pkg::COEFF_W-1:0]       in_coeff_0;
    logic [lcc_pkg::COEFF_W-1:0]       in_coeff_1;
    logic [lcc_pkg::COEFF_W-1:0]       in_coeff_2;
    logic [lcc_pkg::COEFF_W-1:0]       in_coeff_3;
    logic [lcc_pkg::COEFF_W-1:0]       in_coeff_4;
    logic [lcc_pkg::COEFF_W-1:0]       in_coeff_5;
    logic [lcc_pkg::COEFF_W-1:0]       in_coeff_6;
    logic [lcc_pkg::COEFF_W-1:0]       in_coeff_7;

    modport source (
        output valid, func, in_packed,
        output in_coeff_0, in_coeff_1, in_coeff_2, in_coeff_3,
        output in_coeff_4, in_coeff_5, in_coeff_6, in_coeff_7,
        input  ready
    );

    modport sink (
        input  valid, func, in_packed,
        input  in_coeff_0, in_coeff_1, in_coeff_2, in_coeff_3,
        input  in_coeff_4, in_coeff_5, in_coeff_6, in_coeff_7,
        output ready
    );
endinterface

// File: rtl/lcc_out_if.sv
interface lcc_out_if;
    logic                              valid;
    logic                              ready;
    logic [lcc_pkg::PACKED_W-1:0]      out_packed;
    logic [lcc_pkg::COEFF_W-1:0]       out_coeff_0;
    logic [lcc_pkg::COEFF_W-1:0]       out_coeff_1;
    logic [lcc_pkg::COEFF_W-1:0]       out_coeff_2;
    logic [lcc_pkg::COEFF_W-1:0]       out_coeff_3;
    logic [lcc_pkg::COEFF_W-1:0]       out_coeff_4;
    logic [lcc_pkg::COEFF_W-1:0]       out_coeff_5;
    logic [lcc_pkg::COEFF_W-1:0]       out_coeff_6;
    logic [lcc_pkg::COEFF_W-1:0]       out_coeff_7;

    modport source (
        output valid, out_packed,
        output out_coeff_0, out_coeff_1, out_coeff_2, out_coeff_3,
        output out_coeff_4, out_coeff_5, out_coeff_6, out_coeff_7,
        input  ready
    );

    modport sink (
        input  valid, out_packed,
        input  out_coeff_0, out_coeff_1, out_coeff_2, out_coeff_3,
        input  out_coeff_4, out_coeff_5, out_coeff_6, out_coeff_7,
        output ready
    );
endinterface

// File: rtl/lcc_cfg.sv
module lcc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcc_pkg::ADDR_W-1:0]          paddr,
    input  logic [lcc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lcc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [lcc_pkg::BITS_W-1:0]          bits
);

    logic [lcc_pkg::BITS_W-1:0]    bits_reg;
    logic [lcc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    assign reg_idx = paddr[lcc_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign bits    = bits_reg;

    // Capture the register on the access phase of a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= lcc_pkg::BITS_RESET;
        end
        else if (wr_en && (reg_idx == lcc_pkg::REG_COMPRESS_BITS))
        begin
            bits_reg <= pwdata[lcc_pkg::BITS_W-1:0];
        end
    end

    // Read decode
    always_comb
    begin
        unique case (reg_idx)
            lcc_pkg::REG_COMPRESS_BITS: prdata = lcc_pkg::APB_DATA_W'(bits_reg);
            default:                    prdata = '0;
        endcase
    end

endmodule

// File: rtl/lcc_lane.sv
module lcc_lane #(
    parameter int MODULUS = 3329
) (
    input  logic                             clk,
    input  lcc_pkg::lcc_ctl_t                ctl,
    input  logic [lcc_pkg::COEFF_W-1:0]      coeff,
    input  logic [lcc_pkg::VAL_W-1:0]        value,
    output logic [lcc_pkg::COEFF_W-1:0]      result
);

    localparam int NUM_W  = lcc_pkg::NUM_W;
    localparam int PROD_W = NUM_W + lcc_pkg::COEFF_W;
    localparam logic [lcc_pkg::COEFF_W-1:0] Q_C    = lcc_pkg::COEFF_W'(MODULUS);
    localparam logic [NUM_W-1:0]            Q_N    = NUM_W'(MODULUS);
    localparam logic [NUM_W-1:0]            HALF_Q = NUM_W'(MODULUS / 2);
    // floor(2^NUM_W / Q): quotient estimate is low by at most one
    localparam logic [NUM_W-1:0]            RECIP  = NUM_W'((2 ** NUM_W) / MODULUS);

    logic [lcc_pkg::COEFF_W-1:0] reduced;
    logic [NUM_W-1:0]            num;
    logic [NUM_W-1:0]            opnd1_next;
    logic [NUM_W-1:0]            opnd1_reg;
    logic [2*NUM_W-1:0]          recip_prod;
    logic [NUM_W-1:0]            expand_prod;
    logic [NUM_W-1:0]            mul2_next;
    logic [NUM_W-1:0]            mul2_reg;
    logic [NUM_W-1:0]            opnd2_reg;
    logic [PROD_W-1:0]           back_prod;
    logic [NUM_W-1:0]            rem;
    logic [NUM_W-1:0]            quot;
    logic [lcc_pkg::VAL_W-1:0]   code;
    logic [NUM_W-1:0]            round_sum;
    logic [NUM_W-1:0]            expanded;
    logic [lcc_pkg::COEFF_W-1:0] result_next;
    logic [lcc_pkg::COEFF_W-1:0] result_reg;

    // Stage 1: reduce once, scale and add half modulus, or take the value when decompressing
    always_comb
    begin
        reduced    = (coeff >= Q_C) ? coeff - Q_C : coeff;
        num        = (NUM_W'(reduced) << ctl.d0) + HALF_Q;
        opnd1_next = (ctl.func0 == lcc_pkg::FUNC_DECOMPRESS) ? NUM_W'(value) : num;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            opnd1_reg <= opnd1_next;
        end
    end

    // Stage 2: reciprocal multiply or v * Q
    always_comb
    begin
        recip_prod  = (2*NUM_W)'(opnd1_reg) * (2*NUM_W)'(RECIP);
        expand_prod = NUM_W'(opnd1_reg[lcc_pkg::VAL_W-1:0]) * Q_N;
        mul2_next   = (ctl.func1 == lcc_pkg::FUNC_DECOMPRESS) ? expand_prod
                                                               : recip_prod[2*NUM_W-1:NUM_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            mul2_reg  <= mul2_next;
            opnd2_reg <= opnd1_reg;
        end
    end

    // Stage 3: correct the quotient, or round and shift the expansion
    always_comb
    begin
        back_prod   = PROD_W'(mul2_reg) * PROD_W'(Q_C);
        rem         = opnd2_reg - back_prod[NUM_W-1:0];
        quot        = mul2_reg + NUM_W'(rem >= Q_N);
        code        = quot[lcc_pkg::VAL_W-1:0] & lcc_pkg::bits_mask(ctl.d2);
        round_sum   = mul2_reg + NUM_W'(lcc_pkg::round_bit(ctl.d2));
        expanded    = round_sum >> ctl.d2;
        result_next = (ctl.func2 == lcc_pkg::FUNC_DECOMPRESS) ? expanded[lcc_pkg::COEFF_W-1:0]
                                                               : lcc_pkg::COEFF_W'(code);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/lattice_coeff_compress_pack.sv
// Pipeline: four register stages, the three lane stages plus the packing
// output register. Throughput: one group of eight coefficients per cycle
// while the receiver is ready; each stage advances when it is empty or its
// successor advances, so bubbles collapse under stall.
// Reset: rst_n clears all stage valid bits and sets compress_bits to 4.
module lattice_coeff_compress_pack #(
    parameter int MODULUS = 3329
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lcc_in_if.sink                              in_ch,
    lcc_out_if.source                           out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcc_pkg::ADDR_W-1:0]          paddr,
    input  logic [lcc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lcc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int GS = lcc_pkg::GROUP_SIZE;
    localparam int CW = lcc_pkg::COEFF_W;
    localparam int VW = lcc_pkg::VAL_W;
    localparam int BW = lcc_pkg::BITS_W;
    localparam int PW = lcc_pkg::PACKED_W;

    logic [BW-1:0]     bits_raw;
    logic [BW-1:0]     d_in;
    logic [CW-1:0]     coeff_in [GS];
    logic [VW-1:0]     value_in [GS];
    logic [CW-1:0]     res      [GS];

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              ld1, ld2, ld3, ld4;
    logic              func1_reg, func2_reg, func3_reg;
    logic [BW-1:0]     d1_reg, d2_reg, d3_reg;
    lcc_pkg::lcc_ctl_t ctl;

    logic [PW-1:0]     packed_val;
    logic [PW-1:0]     out_packed_next;
    logic [PW-1:0]     out_packed_reg;
    logic [CW-1:0]     out_coeff_next [GS];
    logic [CW-1:0]     out_coeff_reg  [GS];

    // Configuration register
    lcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bits    (bits_raw)
    );

    assign d_in = lcc_pkg::clamp_bits(bits_raw);

    assign coeff_in[0] = in_ch.in_coeff_0;
    assign coeff_in[1] = in_ch.in_coeff_1;
    assign coeff_in[2] = in_ch.in_coeff_2;
    assign coeff_in[3] = in_ch.in_coeff_3;
    assign coeff_in[4] = in_ch.in_coeff_4;
    assign coeff_in[5] = in_ch.in_coeff_5;
    assign coeff_in[6] = in_ch.in_coeff_6;
    assign coeff_in[7] = in_ch.in_coeff_7;

    // Unpack eight d-bit values, LSB first
    always_comb
    begin
        for (int j = 0; j < GS; j++)
        begin
            value_in[j] = '0;
        end
        case (d_in)
            3'd1:
            begin
                for (int j = 0; j < GS; j++) value_in[j] = VW'(in_ch.in_packed[j*1 +: 1]);
            end
            3'd2:
            begin
                for (int j = 0; j < GS; j++) value_in[j] = VW'(in_ch.in_packed[j*2 +: 2]);
            end
            3'd3:
            begin
                for (int j = 0; j < GS; j++) value_in[j] = VW'(in_ch.in_packed[j*3 +: 3]);
            end
            3'd4:
            begin
                for (int j = 0; j < GS; j++) value_in[j] = VW'(in_ch.in_packed[j*4 +: 4]);
            end
            default:
            begin
                for (int j = 0; j < GS; j++) value_in[j] = in_ch.in_packed[j*5 +: 5];
            end
        endcase
    end

    // Stage advance: a stage loads when empty or when its successor loads
    assign ld4 = !v4_reg || out_ch.ready;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign in_ch.ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_ch.valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // Mode and width travel with the data
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            func1_reg <= in_ch.func;
            d1_reg    <= d_in;
        end
        if (ld2)
        begin
            func2_reg <= func1_reg;
            d2_reg    <= d1_reg;
        end
        if (ld3)
        begin
            func3_reg <= func2_reg;
            d3_reg    <= d2_reg;
        end
    end

    always_comb
    begin
        ctl.ld1   = ld1;
        ctl.ld2   = ld2;
        ctl.ld3   = ld3;
        ctl.func0 = in_ch.func;
        ctl.d0    = d_in;
        ctl.func1 = func1_reg;
        ctl.func2 = func2_reg;
        ctl.d2    = d2_reg;
    end

    // Eight coefficient lanes
    for (genvar g = 0; g < GS; g++)
    begin : g_lane
        lcc_lane #(
            .MODULUS (MODULUS)
        ) u_lane (
            .clk    (clk),
            .ctl    (ctl),
            .coeff  (coeff_in[g]),
            .value  (value_in[g]),
            .result (res[g])
        );
    end

    // Pack the compressed codes, LSB first
    always_comb
    begin
        packed_val = '0;
        case (d3_reg)
            3'd1:
            begin
                for (int j = 0; j < GS; j++) packed_val[j*1 +: 1] = res[j][0:0];
            end
            3'd2:
            begin
                for (int j = 0; j < GS; j++) packed_val[j*2 +: 2] = res[j][1:0];
            end
            3'd3:
            begin
                for (int j = 0; j < GS; j++) packed_val[j*3 +: 3] = res[j][2:0];
            end
            3'd4:
            begin
                for (int j = 0; j < GS; j++) packed_val[j*4 +: 4] = res[j][3:0];
            end
            default:
            begin
                for (int j = 0; j < GS; j++) packed_val[j*5 +: 5] = res[j][4:0];
            end
        endcase
    end

    // Zero the fields the mode does not use
    always_comb
    begin
        out_packed_next = (func3_reg == lcc_pkg::FUNC_DECOMPRESS) ? '0 : packed_val;
        for (int j = 0; j < GS; j++)
        begin
            out_coeff_next[j] = (func3_reg == lcc_pkg::FUNC_DECOMPRESS) ? res[j] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            out_packed_reg <= out_packed_next;
            for (int j = 0; j < GS; j++)
            begin
                out_coeff_reg[j] <= out_coeff_next[j];
            end
        end
    end

    assign out_ch.valid       = v4_reg;
    assign out_ch.out_packed  = out_packed_reg;
    assign out_ch.out_coeff_0 = out_coeff_reg[0];
    assign out_ch.out_coeff_1 = out_coeff_reg[1];
    assign out_ch.out_coeff_2 = out_coeff_reg[2];
    assign out_ch.out_coeff_3 = out_coeff_reg[3];
    assign out_ch.out_coeff_4 = out_coeff_reg[4];
    assign out_ch.out_coeff_5 = out_coeff_reg[5];
    assign out_ch.out_coeff_6 = out_coeff_reg[6];
    assign out_ch.out_coeff_7 = out_coeff_reg[7];

endmodule

// File: rtl/lcc_checker.sv
`include "lattice_coeff_compress_pack_assert.svh"

module lcc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [lcc_pkg::PACKED_W-1:0]        out_packed,
    input  logic [lcc_pkg::COEFF_W-1:0]         out_coeff_0,
    input  logic [lcc_pkg::COEFF_W-1:0]         out_coeff_1,
    input  logic [lcc_pkg::COEFF_W-1:0]         out_coeff_2,
    input  logic [lcc_pkg::COEFF_W-1:0]         out_coeff_3,
    input  logic [lcc_pkg::COEFF_W-1:0]         out_coeff_4,
    input  logic [lcc_pkg::COEFF_W-1:0]         out_coeff_5,
    input  logic [lcc_pkg::COEFF_W-1:0]         out_coeff_6,
    input  logic [lcc_pkg::COEFF_W-1:0]         out_coeff_7,
    input  logic                                psel,
    input  logic                                pwrite,
    input  logic [lcc_pkg::APB_DATA_W-1:0]      prdata,
    input  logic                                pready
);

    logic coeff_any;

    assign coeff_any = (out_coeff_0 != '0) || (out_coeff_1 != '0) ||
                       (out_coeff_2 != '0) || (out_coeff_3 != '0) ||
                       (out_coeff_4 != '0) || (out_coeff_5 != '0) ||
                       (out_coeff_6 != '0) || (out_coeff_7 != '0);

    // A stalled result stays valid and holds its packed payload
    `LCC_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_packed), "result changed while stalled")

    // Only one of the two result forms carries data
    `LCC_ASSERT_CLK(a_mode_excl, out_valid && (out_packed != '0) |-> !coeff_any, "packed and coefficient results both nonzero")

    // Register reads show only the three defined bits
    `LCC_ASSERT_CLK(a_prdata_range, psel && !pwrite |-> (prdata[lcc_pkg::APB_DATA_W-1:lcc_pkg::BITS_W] == '0), "read data beyond register width")

    // The port never inserts wait states
    `LCC_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind lattice_coeff_compress_pack lcc_checker u_lcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_packed  (out_ch.out_packed),
    .out_coeff_0 (out_ch.out_coeff_0),
    .out_coeff_1 (out_ch.out_coeff_1),
    .out_coeff_2 (out_ch.out_coeff_2),
    .out_coeff_3 (out_ch.out_coeff_3),
    .out_coeff_4 (out_ch.out_coeff_4),
    .out_coeff_5 (out_ch.out_coeff_5),
    .out_coeff_6 (out_ch.out_coeff_6),
    .out_coeff_7 (out_ch.out_coeff_7),
    .psel        (psel),
    .pwrite      (pwrite),
    .prdata      (prdata),
    .pready      (pready)
);

// File: tb/lattice_coeff_compress_pack_tb.sv
`timescale 1ns / 1ps

module lattice_coeff_compress_pack_tb;

    localparam int GS = lcc_pkg::GROUP_SIZE;
    localparam int CW = lcc_pkg::COEFF_W;
    localparam int BW = lcc_pkg::BITS_W;
    localparam int PW = lcc_pkg::PACKED_W;
    localparam int DW = lcc_pkg::APB_DATA_W;
    localparam int IW = lcc_pkg::REG_IDX_W;

    localparam logic FN_CMP = lcc_pkg::FUNC_COMPRESS;
    localparam logic FN_DEC = lcc_pkg::FUNC_DECOMPRESS;

    localparam int              Q_MOD       = 3329;
    localparam longint unsigned Q_MOD64     = longint'(Q_MOD);
    localparam int              LATENCY     = 4;
    localparam int              HOLD_CYCLES = 64;
    localparam int              BLOCKS      = 5;
    localparam int              BLOCK_ITEMS = 57;
    localparam int              N_DIR       = 25;
    localparam int              N_PHASES    = 4;

    // Second register slot, not implemented: writes there must be dropped
    localparam logic [IW-1:0] REG_SPARE = 1'b1;

    typedef logic [GS-1:0][CW-1:0] coeff_vec_t;

    typedef struct packed {
        logic [PW-1:0] pk;
        coeff_vec_t    co;
    } grp_result_t;

    typedef struct packed {
        logic [BW-1:0] bits;
        logic          func;
        logic [PW-1:0] pk;
        coeff_vec_t    co;
        logic          has_exp;
        logic [PW-1:0] exp_pk;
        coeff_vec_t    exp_co;
    } stim_row_t;

    localparam coeff_vec_t CO_ZERO = '0;
    localparam coeff_vec_t CO_MAX  = {GS{12'hFFF}};
    localparam coeff_vec_t CO_MID  = {GS{12'd1665}};
    localparam coeff_vec_t CO_TOP  = {GS{12'd3328}};
    localparam coeff_vec_t CO_HALF = {GS{12'd1665}};
    localparam coeff_vec_t CO_EDGE = {12'd2496, 12'd832, 12'd4095, 12'd0,
                                      12'd1665, 12'd1664, 12'd3329, 12'd3328};

    logic clk;
    logic rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lcc_pkg::ADDR_W-1:0]    paddr;
    logic [DW-1:0]                 pwdata;
    logic [DW-1:0]                 prdata;
    logic                          pready;

    lcc_in_if  in_bus ();
    lcc_out_if out_bus ();

    lattice_coeff_compress_pack #(
        .MODULUS (Q_MOD)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_bus),
        .out_ch  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Directed groups: extremes, both modes, every width setting including the
    // saturated ones, and ignored fields carrying junk
    stim_row_t dir_tab [N_DIR] = '{
        '{3'd4, FN_CMP, 40'h0,            CO_ZERO, 1'b1, 40'h0,  CO_ZERO},
        '{3'd4, FN_CMP, 40'hFF_FFFF_FFFF, CO_MAX,  1'b0, 40'h0,  CO_ZERO},
        '{3'd4, FN_CMP, 40'h0,            CO_EDGE, 1'b0, 40'h0,  CO_ZERO},
        '{3'd4, FN_DEC, 40'hFF_FFFF_FFFF, CO_ZERO, 1'b0, 40'h0,  CO_ZERO},
        '{3'd4, FN_DEC, 40'h0,            CO_MAX,  1'b1, 40'h0,  CO_ZERO},
        '{3'd4, FN_DEC, 40'h12_3456_789A, CO_EDGE, 1'b0, 40'h0,  CO_ZERO},
        '{3'd1, FN_CMP, 40'h0,            CO_MID,  1'b1, 40'hFF, CO_ZERO},
        '{3'd1, FN_CMP, 40'hFF_FFFF_FFFF, CO_ZERO, 1'b1, 40'h0,  CO_ZERO},
        '{3'd1, FN_CMP, 40'h0,            CO_EDGE, 1'b0, 40'h0,  CO_ZERO},
        '{3'd1, FN_DEC, 40'hFF_FFFF_FFFF, CO_ZERO, 1'b1, 40'h0,  CO_HALF},
        '{3'd1, FN_DEC, 40'hAB_CDEF_01A5, CO_MAX,  1'b0, 40'h0,  CO_ZERO},
        '{3'd0, FN_DEC, 40'h00_0000_00FF, CO_ZERO, 1'b1, 40'h0,  CO_HALF},
        '{3'd0, FN_CMP, 40'h0,            CO_EDGE, 1'b0, 40'h0,  CO_ZERO},
        '{3'd2, FN_CMP, 40'h0,            CO_EDGE, 1'b0, 40'h0,  CO_ZERO},
        '{3'd2, FN_DEC, 40'hFF_FFFF_FFFF, CO_ZERO, 1'b0, 40'h0,  CO_ZERO},
        '{3'd3, FN_CMP, 40'h0,            CO_TOP,  1'b0, 40'h0,  CO_ZERO},
        '{3'd3, FN_DEC, 40'h5A_5A5A_5A5A, CO_ZERO, 1'b0, 40'h0,  CO_ZERO},
        '{3'd5, FN_CMP, 40'h0,            CO_MAX,  1'b0, 40'h0,  CO_ZERO},
        '{3'd5, FN_CMP, 40'h0,            CO_EDGE, 1'b0, 40'h0,  CO_ZERO},
        '{3'd5, FN_DEC, 40'hFF_FFFF_FFFF, CO_ZERO, 1'b0, 40'h0,  CO_ZERO},
        '{3'd5, FN_DEC, 40'h0,            CO_MAX,  1'b1, 40'h0,  CO_ZERO},
        '{3'd6, FN_DEC, 40'hFF_FFFF_FFFF, CO_ZERO, 1'b0, 40'h0,  CO_ZERO},
        '{3'd6, FN_CMP, 40'h0,            CO_EDGE, 1'b0, 40'h0,  CO_ZERO},
        '{3'd7, FN_DEC, 40'h55_5555_5555, CO_ZERO, 1'b0, 40'h0,  CO_ZERO},
        '{3'd7, FN_CMP, 40'h0,            CO_TOP,  1'b0, 40'h0,  CO_ZERO}
    };

    // Shadow of the width register and the results still owed by the block
    logic [BW-1:0] cfg_bits;
    grp_result_t   owed_groups [$];
    int            n_errors;
    int unsigned   src_idle_pct;
    int unsigned   snk_stall_pct;
    bit            hold_req;

    // Compute the packed or unpacked group for the given raw width setting
    function automatic grp_result_t squeeze_group(input logic [BW-1:0] raw,
                                                  input logic fn,
                                                  input logic [PW-1:0] pk,
                                                  input coeff_vec_t co);
        grp_result_t     r;
        int unsigned     d;
        longint unsigned c;
        longint unsigned q;
        longint unsigned v;
        longint unsigned vmask;
        r = '0;
        d = 32'(raw);
        if (raw < lcc_pkg::BITS_MIN) d = 32'(lcc_pkg::BITS_MIN);
        if (raw > lcc_pkg::BITS_MAX) d = 32'(lcc_pkg::BITS_MAX);
        vmask = (64'd1 << d) - 64'd1;
        for (int j = 0; j < GS; j++)
        begin
            if (fn == FN_CMP)
            begin
                c = 64'(co[j]);
                if (c >= Q_MOD64) c = c - Q_MOD64;
                q = (((c << d) + Q_MOD64 / 64'd2) / Q_MOD64) & vmask;
                r.pk = r.pk | PW'(q << (j * d));
            end
            else
            begin
                v = 64'(pk >> (j * d)) & vmask;
                r.co[j] = CW'((v * Q_MOD64 + (64'd1 << (d - 1))) >> d);
            end
        end
        return r;
    endfunction

    // Offer one group, with random idle cycles ahead of it, and log what it owes
    task automatic offer_group(input logic fn, input logic [PW-1:0] pk,
                               input coeff_vec_t co, input logic has_exp,
                               input grp_result_t fixed_res);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.func       <= fn;
        in_bus.in_packed  <= pk;
        in_bus.in_coeff_0 <= co[0];
        in_bus.in_coeff_1 <= co[1];
        in_bus.in_coeff_2 <= co[2];
        in_bus.in_coeff_3 <= co[3];
        in_bus.in_coeff_4 <= co[4];
        in_bus.in_coeff_5 <= co[5];
        in_bus.in_coeff_6 <= co[6];
        in_bus.in_coeff_7 <= co[7];
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        if (has_exp)
            owed_groups.push_back(fixed_res);
        else
            owed_groups.push_back(squeeze_group(cfg_bits, fn, pk, co));
    endtask

    // Drop valid and wait until every owed result has come out
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (owed_groups.size() != 0) @(posedge clk);
    endtask

    // Write one register over APB, then read the width register back
    task automatic program_bits(input logic [IW-1:0] idx,
                                input logic [BW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {(DW - BW)'($urandom()), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == lcc_pkg::REG_COMPRESS_BITS) cfg_bits = val;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {lcc_pkg::REG_COMPRESS_BITS, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[BW-1:0] !== cfg_bits)
        begin
            n_errors++;
            $display("%0t: compress_bits readback expected %0d actual %0d",
                     $time, cfg_bits, prdata[BW-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Run limit
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: check each result transaction, then pick the next ready
    initial
    begin
        grp_result_t got;
        grp_result_t want;
        int          hold_left;
        hold_left = 0;
        out_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_bus.valid && out_bus.ready)
            begin
                got.pk    = out_bus.out_packed;
                got.co[0] = out_bus.out_coeff_0;
                got.co[1] = out_bus.out_coeff_1;
                got.co[2] = out_bus.out_coeff_2;
                got.co[3] = out_bus.out_coeff_3;
                got.co[4] = out_bus.out_coeff_4;
                got.co[5] = out_bus.out_coeff_5;
                got.co[6] = out_bus.out_coeff_6;
                got.co[7] = out_bus.out_coeff_7;
                if (owed_groups.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result expected none actual packed %h", $time, got.pk);
                end
                else
                begin
                    want = owed_groups.pop_front();
                    if (got.pk !== want.pk)
                    begin
                        n_errors++;
                        $display("%0t: out_packed expected %h actual %h",
                                 $time, want.pk, got.pk);
                    end
                    for (int j = 0; j < GS; j++)
                    begin
                        if (got.co[j] !== want.co[j])
                        begin
                            n_errors++;
                            $display("%0t: out_coeff_%0d expected %0d actual %0d",
                                     $time, j, want.co[j], got.co[j]);
                        end
                    end
                end
            end
            // Long hold-off counted here; otherwise stall at random
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_bus.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // Stimulus
    initial
    begin
        grp_result_t   fixed_res;
        logic          fn;
        logic [PW-1:0] pk;
        coeff_vec_t    co;
        int            pick;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_bus.valid      = 1'b0;
        in_bus.func       = FN_CMP;
        in_bus.in_packed  = '0;
        in_bus.in_coeff_0 = '0;
        in_bus.in_coeff_1 = '0;
        in_bus.in_coeff_2 = '0;
        in_bus.in_coeff_3 = '0;
        in_bus.in_coeff_4 = '0;
        in_bus.in_coeff_5 = '0;
        in_bus.in_coeff_6 = '0;
        in_bus.in_coeff_7 = '0;
        cfg_bits          = lcc_pkg::BITS_RESET;
        n_errors          = 0;
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        hold_req          = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; reprogram the width whenever a row asks for another
        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_tab[i].bits != cfg_bits)
            begin
                wait_drained();
                program_bits(lcc_pkg::REG_COMPRESS_BITS, dir_tab[i].bits);
            end
            fixed_res.pk = dir_tab[i].exp_pk;
            fixed_res.co = dir_tab[i].exp_co;
            offer_group(dir_tab[i].func, dir_tab[i].pk, dir_tab[i].co,
                        dir_tab[i].has_exp, fixed_res);
        end

        // A write to the unused slot must leave the width alone
        wait_drained();
        program_bits(REG_SPARE, 3'd2);
        fixed_res = '0;

        // Random groups: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            for (int b = 0; b < BLOCKS; b++)
            begin
                wait_drained();
                src_idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 9 : 0;
                snk_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 9 : 0;
                program_bits(lcc_pkg::REG_COMPRESS_BITS, BW'($urandom_range(0, 7)));
                // Hold the receiver off so the pipeline fills and stalls input
                if (ph == 0 && b == 0) hold_req = 1'b1;
                for (int k = 0; k < BLOCK_ITEMS; k++)
                begin
                    fn = 1'($urandom_range(0, 1));
                    pk = {8'($urandom_range(0, 255)), 32'($urandom())};
                    for (int j = 0; j < GS; j++)
                    begin
                        pick = int'($urandom_range(0, 7));
                        case (pick)
                            0:       co[j] = CW'($urandom_range(Q_MOD - 2, Q_MOD + 1));
                            1:       co[j] = CW'($urandom_range(4000, 4095));
                            2:       co[j] = CW'($urandom_range(0, 20));
                            default: co[j] = CW'($urandom_range(0, 4095));
                        endcase
                    end
                    offer_group(fn, pk, co, 1'b0, fixed_res);
                end
            end
        end

        // Drain and let any stray result show up
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
